[sv/line_segment_intersection_assert.svh]
// Assertion macros shared by the line segment intersection RTL.
`ifndef LINE_SEGMENT_INTERSECTION_ASSERT_SVH
`define LINE_SEGMENT_INTERSECTION_ASSERT_SVH

// Implication checked in the same cycle.
`define LSI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// Implication checked in the next cycle.
`define LSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next cycle check failed");

`endif

[sv/lsi_pkg.sv]
// Shared types and constants for the line segment intersection block.
package lsi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int EPS_WIDTH       = 32;
  localparam logic [EPS_WIDTH-1:0] EPS_RESET = 32'd4295;
  localparam int OFS_LOG2        = 40;
  localparam int QUO_WIDTH       = OFS_LOG2 + 1;

  typedef enum logic [1:0] {
    OP_LINES     = 2'd0,
    OP_SEGMENTS  = 2'd1,
    OP_FOOT_LINE = 2'd2,
    OP_FOOT_SEG  = 2'd3
  } opcode_e;

  typedef struct packed {
    logic parallel;
    logic in_bounds;
    logic neg_ta;
    logic neg_tc;
    logic neg_ox;
    logic neg_oy;
  } lsi_flags_t;

endpackage

[sv/lsi_front.sv]
// Front pipeline: differences, cross products, bound tests and dividends.
module lsi_front #(
  parameter int CW = lsi_pkg::COORD_WIDTH_DEF,
  parameter int FB = lsi_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [1:0]                     op_i,
  input  logic signed [CW-1:0]           ax_i,
  input  logic signed [CW-1:0]           ay_i,
  input  logic signed [CW-1:0]           bx_i,
  input  logic signed [CW-1:0]           by_i,
  input  logic signed [CW-1:0]           cx_i,
  input  logic signed [CW-1:0]           cy_i,
  input  logic signed [CW-1:0]           dx_i,
  input  logic signed [CW-1:0]           dy_i,
  input  logic [lsi_pkg::EPS_WIDTH-1:0]  eps_i,
  output logic                           valid_o,
  output lsi_pkg::lsi_flags_t            flags_o,
  output logic signed [CW-1:0]           ax_o,
  output logic signed [CW-1:0]           ay_o,
  output logic [2*(CW+1):0]              den_o,
  output logic [2*(CW+1)+((CW+1) > FB ? (CW+1) : FB):0] num_ta_o,
  output logic [2*(CW+1)+((CW+1) > FB ? (CW+1) : FB):0] num_tc_o,
  output logic [2*(CW+1)+((CW+1) > FB ? (CW+1) : FB):0] num_ox_o,
  output logic [2*(CW+1)+((CW+1) > FB ? (CW+1) : FB):0] num_oy_o
);

  localparam int E   = CW + 1;
  localparam int P   = 2 * E;
  localparam int NAW = P + 1;
  localparam int NW  = NAW + (E > FB ? E : FB);
  localparam int LW  = (NAW + 1) / 2;
  localparam int HW  = NAW - LW;

  // Stage 1: differences.
  logic signed [E-1:0] ddx, ddy, dex, dey, dfx, dfy;
  logic                v1_q;
  logic [1:0]          op1_q;
  logic signed [CW-1:0] ax1_q, ay1_q;
  logic signed [E-1:0] dx1_q, dy1_q, ex1_q, ey1_q, fx1_q, fy1_q;

  always_comb begin
    ddx = E'(bx_i) - E'(ax_i);
    ddy = E'(by_i) - E'(ay_i);
    dfx = E'(ax_i) - E'(cx_i);
    dfy = E'(ay_i) - E'(cy_i);
    if (op_i == lsi_pkg::OP_FOOT_LINE || op_i == lsi_pkg::OP_FOOT_SEG) begin
      dex = -ddy;
      dey = ddx;
    end else begin
      dex = E'(dx_i) - E'(cx_i);
      dey = E'(dy_i) - E'(cy_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q <= op_i;
      ax1_q <= ax_i;
      ay1_q <= ay_i;
      dx1_q <= ddx;
      dy1_q <= ddy;
      ex1_q <= dex;
      ey1_q <= dey;
      fx1_q <= dfx;
      fy1_q <= dfy;
    end
  end

  // Stage 2: the six products of the cross terms.
  logic                v2_q;
  logic [1:0]          op2_q;
  logic signed [CW-1:0] ax2_q, ay2_q;
  logic signed [E-1:0] dx2_q, dy2_q;
  logic signed [P-1:0] pda_q, pdb_q, paa_q, pab_q, pca_q, pcb_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op2_q <= op1_q;
      ax2_q <= ax1_q;
      ay2_q <= ay1_q;
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;
      pda_q <= dy1_q * ex1_q;
      pdb_q <= dx1_q * ey1_q;
      paa_q <= fx1_q * ey1_q;
      pab_q <= fy1_q * ex1_q;
      pca_q <= dy1_q * fx1_q;
      pcb_q <= dx1_q * fy1_q;
    end
  end

  // Stage 3: cross products.
  logic                  v3_q;
  logic [1:0]            op3_q;
  logic signed [CW-1:0]  ax3_q, ay3_q;
  logic signed [E-1:0]   dx3_q, dy3_q;
  logic signed [NAW-1:0] den3_q, na3_q, nc3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op3_q  <= op2_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      dx3_q  <= dx2_q;
      dy3_q  <= dy2_q;
      den3_q <= NAW'(pda_q) - NAW'(pdb_q);
      na3_q  <= NAW'(paa_q) - NAW'(pab_q);
      nc3_q  <= NAW'(pca_q) - NAW'(pcb_q);
    end
  end

  // Stage 4: magnitudes, tests and partial products of the offsets.
  logic [NAW-1:0]      mden, mna, mnc;
  logic [E-1:0]        mdx, mdy;
  logic                ur_na, ur_nc, bounds;
  lsi_pkg::lsi_flags_t flags_d;

  always_comb begin
    mden = den3_q[NAW-1] ? NAW'(-den3_q) : NAW'(den3_q);
    mna  = na3_q[NAW-1] ? NAW'(-na3_q) : NAW'(na3_q);
    mnc  = nc3_q[NAW-1] ? NAW'(-nc3_q) : NAW'(nc3_q);
    mdx  = dx3_q[E-1] ? E'(-dx3_q) : E'(dx3_q);
    mdy  = dy3_q[E-1] ? E'(-dy3_q) : E'(dy3_q);
    ur_na = (na3_q == '0) ||
            ((na3_q[NAW-1] == den3_q[NAW-1]) && (mden >= mna));
    ur_nc = (nc3_q == '0) ||
            ((nc3_q[NAW-1] == den3_q[NAW-1]) && (mden >= mnc));
    unique case (lsi_pkg::opcode_e'(op3_q))
      lsi_pkg::OP_LINES:     bounds = 1'b1;
      lsi_pkg::OP_SEGMENTS:  bounds = ur_na & ur_nc;
      lsi_pkg::OP_FOOT_LINE: bounds = 1'b1;
      lsi_pkg::OP_FOOT_SEG:  bounds = ur_na;
      default:               bounds = 1'b1;
    endcase
    flags_d.parallel  = (den3_q == '0) || (mden < NAW'(eps_i));
    flags_d.in_bounds = bounds;
    flags_d.neg_ta    = na3_q[NAW-1] ^ den3_q[NAW-1];
    flags_d.neg_tc    = nc3_q[NAW-1] ^ den3_q[NAW-1];
    flags_d.neg_ox    = na3_q[NAW-1] ^ den3_q[NAW-1] ^ dx3_q[E-1];
    flags_d.neg_oy    = na3_q[NAW-1] ^ den3_q[NAW-1] ^ dy3_q[E-1];
  end

  logic                 v4_q;
  lsi_pkg::lsi_flags_t  flags4_q;
  logic signed [CW-1:0] ax4_q, ay4_q;
  logic [NAW-1:0]       mden4_q, mna4_q, mnc4_q;
  logic [LW+E-1:0]      plx_q, ply_q;
  logic [HW+E-1:0]      phx_q, phy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags4_q <= flags_d;
      ax4_q    <= ax3_q;
      ay4_q    <= ay3_q;
      mden4_q  <= mden;
      mna4_q   <= mna;
      mnc4_q   <= mnc;
      plx_q    <= mna[LW-1:0] * mdx;
      phx_q    <= mna[NAW-1:LW] * mdx;
      ply_q    <= mna[LW-1:0] * mdy;
      phy_q    <= mna[NAW-1:LW] * mdy;
    end
  end

  // Stage 5: dividends.
  logic v5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_o  <= flags4_q;
      ax_o     <= ax4_q;
      ay_o     <= ay4_q;
      den_o    <= mden4_q;
      num_ta_o <= NW'(mna4_q) << FB;
      num_tc_o <= NW'(mnc4_q) << FB;
      num_ox_o <= NW'(plx_q) + (NW'(phx_q) << LW);
      num_oy_o <= NW'(ply_q) + (NW'(phy_q) << LW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign valid_o = v5_q;

endmodule

[sv/lsi_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module lsi_div #(
  parameter int NW = 100,
  parameter int DW = 67,
  parameter int QW = lsi_pkg::QUO_WIDTH
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o
);

  logic [DW-1:0] rem_q [0:QW];
  logic [QW-1:0] low_q [0:QW];
  logic [QW-1:0] quo_q [0:QW];
  logic [DW-1:0] den_q [0:QW];
  logic          ovf_q [0:QW];

  // The quotient overflows QW bits when the dividend's high part reaches the divisor.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= (num_i >> QW) >= NW'(den_i);
      rem_q[0] <= DW'(num_i >> QW);
      low_q[0] <= num_i[QW-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DW:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem_q[k-1], low_q[k-1][QW-1]};
      ge    = trial >= {1'b0, den_q[k-1]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(trial - {1'b0, den_q[k-1]}) : trial[DW-1:0];
        low_q[k] <= low_q[k-1] << 1;
        quo_q[k] <= {quo_q[k-1][QW-2:0], ge};
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

[sv/line_segment_intersection.sv]
// An accepted item passes through 5 front stages, QUO_WIDTH + 1 divider stages and
// one output register before its result appears.
// Throughput: one item per cycle while in_stall_o is low; the four dividers are fully pipelined.
// A two-entry output register and skid buffer absorb a stalled consumer.
// Reset clears all valid bits and sets the parallel threshold eps_q to 4295.
module line_segment_intersection #(
  parameter int COORD_WIDTH = lsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = lsi_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic signed [COORD_WIDTH-1:0] point_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_a_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_b_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_c_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_c_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_d_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_d_y_i,
  input  logic                          cfg_we_i,
  input  logic [lsi_pkg::EPS_WIDTH-1:0] cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic signed [COORD_WIDTH-1:0] hit_x_o,
  output logic signed [COORD_WIDTH-1:0] hit_y_o,
  output logic signed [COORD_WIDTH-1:0] param_along_ab_o,
  output logic signed [COORD_WIDTH-1:0] param_along_cd_o
);

  `include "line_segment_intersection_assert.svh"

  localparam int CW  = COORD_WIDTH;
  localparam int E   = CW + 1;
  localparam int NAW = 2 * E + 1;
  localparam int NW  = NAW + (E > FRAC_BITS ? E : FRAC_BITS);
  localparam int QW  = lsi_pkg::QUO_WIDTH;
  localparam int OW  = QW + 1;
  localparam int SW  = OW + 1;
  localparam int DL  = QW + 1;
  localparam logic [QW-1:0] TMAG_N = QW'(1) << (CW - 1);
  localparam logic [QW-1:0] TMAG_P = TMAG_N - QW'(1);
  localparam logic [QW-1:0] OMAG   = QW'(1) << lsi_pkg::OFS_LOG2;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  logic en;
  logic skid_v_q, out_v_q;
  logic [lsi_pkg::EPS_WIDTH-1:0] eps_q;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= lsi_pkg::EPS_RESET;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  logic                 f_valid;
  lsi_pkg::lsi_flags_t  f_flags;
  logic signed [CW-1:0] f_ax, f_ay;
  logic [NAW-1:0]       f_den;
  logic [NW-1:0]        f_num_ta, f_num_tc, f_num_ox, f_num_oy;

  lsi_front #(
    .CW (CW),
    .FB (FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .op_i     (opcode_i),
    .ax_i     (point_a_x_i),
    .ay_i     (point_a_y_i),
    .bx_i     (point_b_x_i),
    .by_i     (point_b_y_i),
    .cx_i     (point_c_x_i),
    .cy_i     (point_c_y_i),
    .dx_i     (point_d_x_i),
    .dy_i     (point_d_y_i),
    .eps_i    (eps_q),
    .valid_o  (f_valid),
    .flags_o  (f_flags),
    .ax_o     (f_ax),
    .ay_o     (f_ay),
    .den_o    (f_den),
    .num_ta_o (f_num_ta),
    .num_tc_o (f_num_tc),
    .num_ox_o (f_num_ox),
    .num_oy_o (f_num_oy)
  );

  logic [QW-1:0] q_ta, q_tc, q_ox, q_oy;
  logic          o_ta, o_tc, o_ox, o_oy;

  lsi_div #(.NW(NW), .DW(NAW), .QW(QW)) u_div_ta (
    .clk_i (clk_i), .en_i (en), .num_i (f_num_ta), .den_i (f_den),
    .quo_o (q_ta), .ovf_o (o_ta)
  );
  lsi_div #(.NW(NW), .DW(NAW), .QW(QW)) u_div_tc (
    .clk_i (clk_i), .en_i (en), .num_i (f_num_tc), .den_i (f_den),
    .quo_o (q_tc), .ovf_o (o_tc)
  );
  lsi_div #(.NW(NW), .DW(NAW), .QW(QW)) u_div_ox (
    .clk_i (clk_i), .en_i (en), .num_i (f_num_ox), .den_i (f_den),
    .quo_o (q_ox), .ovf_o (o_ox)
  );
  lsi_div #(.NW(NW), .DW(NAW), .QW(QW)) u_div_oy (
    .clk_i (clk_i), .en_i (en), .num_i (f_num_oy), .den_i (f_den),
    .quo_o (q_oy), .ovf_o (o_oy)
  );

  // Side information travels beside the dividers.
  logic                 side_v_q     [0:DL-1];
  lsi_pkg::lsi_flags_t  side_flags_q [0:DL-1];
  logic signed [CW-1:0] side_ax_q    [0:DL-1];
  logic signed [CW-1:0] side_ay_q    [0:DL-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DL; k++) begin
        side_v_q[k] <= 1'b0;
      end
    end else if (en) begin
      side_v_q[0] <= f_valid;
      for (int k = 1; k < DL; k++) begin
        side_v_q[k] <= side_v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_flags_q[0] <= f_flags;
      side_ax_q[0]    <= f_ax;
      side_ay_q[0]    <= f_ay;
      for (int k = 1; k < DL; k++) begin
        side_flags_q[k] <= side_flags_q[k-1];
        side_ax_q[k]    <= side_ax_q[k-1];
        side_ay_q[k]    <= side_ay_q[k-1];
      end
    end
  end

  function automatic logic signed [CW-1:0] sat_param(logic [QW-1:0] q, logic ovf, logic neg);
    logic signed [CW-1:0] r;
    if (neg) begin
      r = (ovf || q > TMAG_N) ? CMIN : CW'(-q);
    end else begin
      r = (ovf || q > TMAG_P) ? CMAX : CW'(q);
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] hit_coord(logic signed [CW-1:0] a,
                                                     logic [QW-1:0] q, logic ovf,
                                                     logic neg);
    logic [QW-1:0]        m;
    logic signed [OW-1:0] ofs;
    logic signed [SW-1:0] sum;
    logic signed [CW-1:0] r;
    m   = (ovf || q > OMAG) ? OMAG : q;
    ofs = neg ? -OW'(m) : OW'(m);
    sum = SW'(a) + SW'(ofs);
    if (sum > SW'(CMAX)) begin
      r = CMAX;
    end else if (sum < SW'(CMIN)) begin
      r = CMIN;
    end else begin
      r = CW'(sum);
    end
    return r;
  endfunction

  lsi_pkg::lsi_flags_t  lf;
  logic                 inc_v, inc_found;
  logic signed [CW-1:0] inc_hx, inc_hy, inc_ta, inc_tc;

  always_comb begin
    lf        = side_flags_q[DL-1];
    inc_v     = side_v_q[DL-1];
    inc_found = !lf.parallel && lf.in_bounds;
    inc_ta    = lf.parallel ? '0 : sat_param(q_ta, o_ta, lf.neg_ta);
    inc_tc    = lf.parallel ? '0 : sat_param(q_tc, o_tc, lf.neg_tc);
    inc_hx    = inc_found ? hit_coord(side_ax_q[DL-1], q_ox, o_ox, lf.neg_ox) : '0;
    inc_hy    = inc_found ? hit_coord(side_ay_q[DL-1], q_oy, o_oy, lf.neg_oy) : '0;
  end

  // Output register with one skid entry behind it.
  logic                 out_found_q, skid_found_q;
  logic signed [CW-1:0] out_hx_q, out_hy_q, out_ta_q, out_tc_q;
  logic signed [CW-1:0] skid_hx_q, skid_hy_q, skid_ta_q, skid_tc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= inc_v;
      end
    end else if (inc_v && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_found_q <= skid_found_q;
        out_hx_q    <= skid_hx_q;
        out_hy_q    <= skid_hy_q;
        out_ta_q    <= skid_ta_q;
        out_tc_q    <= skid_tc_q;
      end else begin
        out_found_q <= inc_found;
        out_hx_q    <= inc_hx;
        out_hy_q    <= inc_hy;
        out_ta_q    <= inc_ta;
        out_tc_q    <= inc_tc;
      end
    end else if (inc_v && !skid_v_q) begin
      skid_found_q <= inc_found;
      skid_hx_q    <= inc_hx;
      skid_hy_q    <= inc_hy;
      skid_ta_q    <= inc_ta;
      skid_tc_q    <= inc_tc;
    end
  end

  assign out_valid_o      = out_v_q;
  assign found_o          = out_found_q;
  assign hit_x_o          = out_hx_q;
  assign hit_y_o          = out_hy_q;
  assign param_along_ab_o = out_ta_q;
  assign param_along_cd_o = out_tc_q;

  `LSI_ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q)
  `LSI_ASSERT_NEXT(a_skid_drains, skid_v_q && !out_stall_i, !skid_v_q)
  `LSI_ASSERT_IMP(a_miss_zero_hit, out_v_q && !out_found_q,
                  out_hx_q == '0 && out_hy_q == '0)

endmodule
